[hw/rtl/hrid_pkg.sv]
package hrid_pkg;

   localparam logic [7:0] REPORT_ID_PREFIX = 8'h85;
   localparam logic [7:0] LONG_ITEM_MASK   = 8'hf0;
   localparam logic [7:0] LEN_CODE_MASK    = 8'h03;
   localparam logic [1:0] LEN_CODE_FOUR    = 2'd3;

   // One descriptor byte as it moves from the input register to the parser.
   typedef struct packed {
      logic [7:0] desc_byte;
      logic       last_byte;
   } hrid_item_type;

endpackage

[hw/rtl/hid_report_id_detector_unit.sv]
// Report ID detector for HID report descriptors.
// The req_ channel carries one descriptor byte per item in req_desc_byte;
// req_last_byte marks the final byte of a descriptor. The block walks the
// item structure and skips short item data and whole long items, so data
// bytes are never mistaken for a Report ID prefix.
// The rsp_ channel carries one item per descriptor: rsp_numbered is 1 when
// a Report ID prefix was found anywhere in the descriptor.
// An item is accepted when its valid is high and its stall is low.
// Throughput is one byte per cycle, back to back, unless a last byte waits
// for the result slot; it is set by the single parse step between the input
// register and the result register, which holds the result for rsp_valid.
// While rsp_stall holds a result, bytes that are not last keep flowing; a
// last byte waits in the input register until the result slot frees, and
// req_stall then rises only while that register is occupied.
// Synchronous reset empties both registers and returns the walker to the
// item prefix state with no Report ID seen.
module hid_report_id_detector_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_desc_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_numbered
);
   import hrid_pkg::*;

   logic          item_valid;
   hrid_item_type item;
   logic          advance;
   logic          slot_free;
   logic          numbered;

   // A byte leaves the input register unless it is the last one and the
   // result slot is still held by the receiver.
   assign advance = item_valid & (~item.last_byte | slot_free);

   hrid_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_desc_byte (req_desc_byte),
      .req_last_byte (req_last_byte),
      .advance       (advance),
      .item_valid    (item_valid),
      .item          (item)
   );

   hrid_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .item     (item),
      .numbered (numbered)
   );

   hrid_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .load         (advance & item.last_byte),
      .numbered     (numbered),
      .slot_free    (slot_free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_numbered (rsp_numbered)
   );

endmodule

[hw/rtl/hrid_in_stage.sv]
module hrid_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_desc_byte,
   input  logic                  req_last_byte,
   input  logic                  advance,
   output logic                  item_valid,
   output hrid_pkg::hrid_item_type item
);
   import hrid_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   hrid_item_type item_ff;

   // The register can take a new item when it is empty or its item moves on.
   assign req_stall = valid_ff & ~advance;
   assign valid_in  = req_valid ? 1'b1 : (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff.desc_byte <= req_desc_byte;
         item_ff.last_byte <= req_last_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[hw/rtl/hrid_parser.sv]
module hrid_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  hrid_pkg::hrid_item_type item,
   output logic                    numbered
);
   import hrid_pkg::*;

   localparam logic [1:0] PH_PREFIX  = 2'd0;
   localparam logic [1:0] PH_LONGLEN = 2'd1;
   localparam logic [1:0] PH_SKIP    = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [8:0] skip_ff, skip_in;
   logic       seen_ff, seen_in;
   logic [1:0] len_code;
   logic [8:0] short_len;

   assign len_code  = item.desc_byte[1:0] & LEN_CODE_MASK[1:0];
   assign short_len = (len_code == LEN_CODE_FOUR) ? 9'd4 : {7'd0, len_code};

   always_comb begin
      phase_in = phase_ff;
      skip_in  = skip_ff;
      seen_in  = seen_ff;
      if (phase_ff == PH_LONGLEN) begin
         // Length byte: the tag byte and the data bytes follow.
         skip_in  = {1'b0, item.desc_byte} + 9'd1;
         phase_in = PH_SKIP;
      end else if (phase_ff == PH_SKIP && skip_ff != 9'd0) begin
         skip_in = skip_ff - 9'd1;
         if (skip_ff == 9'd1) begin
            phase_in = PH_PREFIX;
         end
      end else begin
         if (item.desc_byte == REPORT_ID_PREFIX) begin
            seen_in = 1'b1;
         end
         if ((item.desc_byte & LONG_ITEM_MASK) == LONG_ITEM_MASK) begin
            phase_in = PH_LONGLEN;
            skip_in  = 9'd0;
         end else if (short_len == 9'd0) begin
            phase_in = PH_PREFIX;
            skip_in  = 9'd0;
         end else begin
            phase_in = PH_SKIP;
            skip_in  = short_len;
         end
      end
   end

   assign numbered = seen_in;

   // The last byte of a descriptor returns the walker to its starting point.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PREFIX;
         skip_ff  <= 9'd0;
         seen_ff  <= 1'b0;
      end else if (advance) begin
         if (item.last_byte) begin
            phase_ff <= PH_PREFIX;
            skip_ff  <= 9'd0;
            seen_ff  <= 1'b0;
         end else begin
            phase_ff <= phase_in;
            skip_ff  <= skip_in;
            seen_ff  <= seen_in;
         end
      end
   end

endmodule

[hw/rtl/hrid_out_stage.sv]
module hrid_out_stage (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  logic numbered,
   output logic slot_free,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_numbered
);

   logic valid_ff, valid_in;
   logic numbered_ff;

   assign slot_free = ~valid_ff | ~rsp_stall;
   assign valid_in  = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         numbered_ff <= numbered;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_numbered = numbered_ff;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import hrid_pkg::*;

   // Receiver hold-off used to fill the block and force it to stall its input.
   localparam int unsigned HOLD_OFF_CYCLES   = 300;
   localparam int unsigned HOLD_OFF_AT_BYTE  = 300;
   // Window of accepted bytes in which neither side idles or stalls.
   localparam int unsigned QUIET_FROM_BYTE   = 800;
   localparam int unsigned QUIET_TO_BYTE     = 1100;
   localparam int unsigned IDLE_PERCENT      = 35;
   localparam int unsigned RANDOM_BYTES      = 1600;
   localparam int unsigned LONGEST_DATA      = 255;
   // Settling time after the last result is taken; leave a little slack.
   localparam int unsigned DRAIN_CYCLES      = 10;
   localparam int unsigned WATCHDOG_LIMIT    = 3000;

   // Walker phases, matching the way a HID descriptor is laid out.
   typedef enum logic [1:0] {
      WALK_PREFIX,
      WALK_LONG_LEN,
      WALK_SKIP
   } walk_phase_type;

   // One descriptor byte as the sender offers it. When pinned is set, the
   // expected answer for the descriptor that this byte closes is typed in
   // here rather than taken from the walker model below.
   typedef struct packed {
      logic [7:0] desc_byte;
      logic       last_byte;
      logic       pinned;
      logic       pinned_numbered;
   } desc_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_desc_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       req_pinned = 1'b0;
   logic       req_pinned_numbered = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_numbered;

   desc_item_type desc_stream[$];
   logic        numbered_expected[$];
   int unsigned bytes_taken = 0;
   int unsigned desc_pos = 0;
   int unsigned fail_count = 0;
   int unsigned stall_left = 0;
   bit          hold_off_done = 1'b0;
   logic        rsp_hold_active = 1'b0;
   int unsigned dead_cycles = 0;

   // Walker model state.
   walk_phase_type walk_phase;
   logic [8:0]  skip_left;
   logic        id_seen;
   bit          answer_ready;
   logic        answer_numbered;
   logic        want_numbered;

   // Directed descriptors. Rows with pinned set carry an answer that can be
   // read straight off the bytes; the rest are left to the walker model.
   desc_item_type directed_rows [23] = '{
      // A lone Report ID prefix that is also the last byte.
      '{8'h85, 1'b1, 1'b1, 1'b1},
      // Smallest and largest byte as one-byte descriptors; 0xff is a long
      // item cut off at its prefix.
      '{8'h00, 1'b1, 1'b1, 1'b0},
      '{8'hff, 1'b1, 1'b1, 1'b0},
      // Long item cut off at its length byte.
      '{8'hfe, 1'b0, 1'b0, 1'b0},
      '{8'h03, 1'b1, 1'b1, 1'b0},
      // Two data bytes equal to the Report ID prefix are skipped, then a real
      // prefix closes the descriptor.
      '{8'h06, 1'b0, 1'b0, 1'b0},
      '{8'h85, 1'b0, 1'b0, 1'b0},
      '{8'h85, 1'b0, 1'b0, 1'b0},
      '{8'h85, 1'b1, 1'b0, 1'b0},
      // Four-byte short item cut off inside its data; no prefix is ever seen.
      '{8'h07, 1'b0, 1'b0, 1'b0},
      '{8'h85, 1'b0, 1'b0, 1'b0},
      '{8'h85, 1'b0, 1'b0, 1'b0},
      '{8'h85, 1'b1, 1'b1, 1'b0},
      // Long item with no data: only its tag byte is skipped.
      '{8'hf1, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 1'b0},
      '{8'h85, 1'b0, 1'b0, 1'b0},
      '{8'h85, 1'b1, 1'b0, 1'b0},
      // Report ID item with its one data byte, then End Collection.
      '{8'h85, 1'b0, 1'b0, 1'b0},
      '{8'h42, 1'b0, 1'b0, 1'b0},
      '{8'hc0, 1'b1, 1'b0, 1'b0},
      // Two empty short items, then a four-byte item cut off at its prefix.
      '{8'h3c, 1'b0, 1'b0, 1'b0},
      '{8'h84, 1'b0, 1'b0, 1'b0},
      '{8'h87, 1'b1, 1'b1, 1'b0}
   };

   hid_report_id_detector_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_desc_byte (req_desc_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_numbered  (rsp_numbered)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Data bytes often equal the Report ID prefix, to catch a walker that
   // looks at bytes it should skip.
   function automatic logic [7:0] pick_data_byte();
      return ($urandom_range(0, 3) == 0) ? REPORT_ID_PREFIX : 8'($urandom_range(0, 255));
   endfunction

   function automatic void clear_walker();
      walk_phase = WALK_PREFIX;
      skip_left  = 9'd0;
      id_seen    = 1'b0;
   endfunction

   // Advances the walker by one descriptor byte. On the last byte it hands
   // back the answer and starts over for the next descriptor.
   function automatic void walk_desc_byte(input logic [7:0] b, input logic last,
                                          output bit ready, output logic numbered);
      logic [1:0] len_code;
      if (walk_phase == WALK_LONG_LEN) begin
         // Length byte; the tag byte and the data bytes are skipped next.
         skip_left  = {1'b0, b} + 9'd1;
         walk_phase = WALK_SKIP;
      end else if (walk_phase == WALK_SKIP && skip_left != 9'd0) begin
         skip_left = skip_left - 9'd1;
         if (skip_left == 9'd0) begin
            walk_phase = WALK_PREFIX;
         end
      end else begin
         // An item prefix. Any other phase falls back to this one.
         if (b == REPORT_ID_PREFIX) begin
            id_seen = 1'b1;
         end
         if ((b & LONG_ITEM_MASK) == LONG_ITEM_MASK) begin
            walk_phase = WALK_LONG_LEN;
            skip_left  = 9'd0;
         end else begin
            len_code  = b[1:0] & LEN_CODE_MASK[1:0];
            skip_left = (len_code == LEN_CODE_FOUR) ? 9'd4 : {7'd0, len_code};
            walk_phase = (skip_left == 9'd0) ? WALK_PREFIX : WALK_SKIP;
         end
      end
      ready    = last;
      numbered = id_seen;
      if (last) begin
         clear_walker();
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   // Builds the byte stream, releases reset, and then waits for the stream to
   // drain before judging the run.
   initial begin : run_control
      logic [7:0]  desc_bytes[$];
      int unsigned shape;
      int unsigned kind;
      int unsigned entry_count;
      int unsigned payload_len;
      logic [7:0]  prefix;
      bit          first_desc;

      foreach (directed_rows[i]) begin
         desc_stream.push_back(directed_rows[i]);
      end

      // Random descriptors. Most are well formed: a few items each, mixing
      // short items, Report ID items and long items. One in ten is cut off
      // at a random byte and one in ten is plain noise. The first one always
      // opens with a long item of the greatest length.
      first_desc = 1'b1;
      while (desc_stream.size() < RANDOM_BYTES) begin
         desc_bytes.delete();
         shape = first_desc ? 9 : $urandom_range(0, 9);
         if (shape == 0) begin
            repeat ($urandom_range(1, 20)) desc_bytes.push_back(pick_data_byte());
         end else begin
            entry_count = $urandom_range(1, 8);
            for (int k = 0; k < entry_count; k++) begin
               kind = $urandom_range(0, 99);
               if ((first_desc && k == 0) || kind < 15) begin
                  desc_bytes.push_back({4'hf, 4'($urandom_range(0, 15))});
                  if ((first_desc && k == 0) || $urandom_range(0, 39) == 0) begin
                     payload_len = LONGEST_DATA;
                  end else begin
                     payload_len = $urandom_range(0, 5);
                  end
                  desc_bytes.push_back(8'(payload_len));
                  repeat (payload_len + 1) desc_bytes.push_back(pick_data_byte());
               end else begin
                  // Short item; its prefix never has the long item nibble.
                  prefix = (kind < 35) ? REPORT_ID_PREFIX : 8'($urandom_range(0, 8'hef));
                  desc_bytes.push_back(prefix);
                  payload_len = (prefix[1:0] == LEN_CODE_FOUR) ? 4 : prefix[1:0];
                  repeat (payload_len) desc_bytes.push_back(pick_data_byte());
               end
            end
            if (shape == 1) begin
               desc_bytes = desc_bytes[0:$urandom_range(0, desc_bytes.size() - 1)];
            end
         end
         first_desc = 1'b0;
         foreach (desc_bytes[i]) begin
            desc_stream.push_back('{desc_bytes[i], (i == desc_bytes.size() - 1),
                                    1'b0, 1'b0});
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (bytes_taken != desc_stream.size() || numbered_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Sender. A stalled item is held as it is. Otherwise the next byte is
   // offered unless this cycle is picked as an idle one; idling stops inside
   // the quiet window and while the receiver holds off, so the block fills.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            desc_pos++;
            bytes_taken <= bytes_taken + 1;
         end
         if (desc_pos < desc_stream.size() &&
             (rsp_hold_active ||
              (bytes_taken >= QUIET_FROM_BYTE && bytes_taken < QUIET_TO_BYTE) ||
              $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            req_valid           <= 1'b1;
            req_desc_byte       <= desc_stream[desc_pos].desc_byte;
            req_last_byte       <= desc_stream[desc_pos].last_byte;
            req_pinned          <= desc_stream[desc_pos].pinned;
            req_pinned_numbered <= desc_stream[desc_pos].pinned_numbered;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver. Once, early in the run, it holds off for a long stretch;
   // otherwise it stalls at random, except inside the quiet window.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall       <= 1'b0;
         rsp_hold_active <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall       <= 1'b1;
         rsp_hold_active <= 1'b1;
      end else if (!hold_off_done && bytes_taken >= HOLD_OFF_AT_BYTE) begin
         hold_off_done    = 1'b1;
         stall_left       = HOLD_OFF_CYCLES - 1;
         rsp_stall       <= 1'b1;
         rsp_hold_active <= 1'b1;
      end else begin
         rsp_hold_active <= 1'b0;
         if (bytes_taken >= QUIET_FROM_BYTE && bytes_taken < QUIET_TO_BYTE) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   // Prediction and checking share one process, so a byte accepted at an
   // edge is always walked before any result at that edge is compared.
   always @(posedge clock) begin
      if (reset) begin
         clear_walker();
      end else begin
         if (req_valid && !req_stall) begin
            walk_desc_byte(req_desc_byte, req_last_byte, answer_ready, answer_numbered);
            if (answer_ready) begin
               numbered_expected.push_back(req_pinned ? req_pinned_numbered
                                                      : answer_numbered);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (numbered_expected.size() == 0) begin
               report_mismatch("result arrived with no descriptor outstanding");
            end else begin
               want_numbered = numbered_expected.pop_front();
               if (rsp_numbered !== want_numbered) begin
                  report_mismatch($sformatf("numbered is %b, expected %b",
                                            rsp_numbered, want_numbered));
               end
            end
         end
      end
   end

   // Watchdog: too many cycles in a row with no item moving on either
   // channel means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         dead_cycles <= 0;
      end else if (dead_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         dead_cycles <= dead_cycles + 1;
      end
   end

endmodule
